// File: hw/rtl/spfs_pkg.sv
// shared constants and types for the period recovery block
`default_nettype none
package spfs_pkg;
	localparam int MOD_BITS_DEF = 16;
	localparam logic [15:0] MODULUS_RST = 16'd15;
	localparam logic [31:0] LCM_MAX = 32'hFFFF_FFFF;
	// divider operation request
	typedef struct packed {
		logic        start;
		logic [64:0] num;
		logic [64:0] den;
	} div_req_t;
	typedef struct packed {
		logic        done;
		logic [64:0] quo;
		logic [64:0] rem;
	} div_rsp_t;
endpackage
`default_nettype wire

// File: hw/rtl/spfs_if.sv
// valid/ready channel interfaces for samples, results and configuration
`default_nettype none
interface spfs_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample;
	logic        last;
	modport source (output valid, sample, last, input ready);
	modport sink (input valid, sample, last, output ready);
endinterface

interface spfs_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] period;
	logic        overflow;
	modport source (output valid, period, overflow, input ready);
	modport sink (input valid, period, overflow, output ready);
endinterface

interface spfs_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;
	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/shor_period_from_samples.sv
// Period recovery from measured samples. Each sample is expanded as a continued fraction
// of sample/Q, Q = 2^(2b) with b the bit length of modulus-1 (1..MOD_BITS); the first
// convergent within 1/(2Q) gives a denominator, folded into a running LCM (saturating,
// sticky overflow) that is emitted and cleared on a sample marked last. One sample at a
// time: all divisions run on one 65-bit restoring divider, and the multiplies on one
// 32x32 multiplier in partial products. A sample marked last also hands over the result,
// holding it until the output is ready, before the next sample is taken.
`default_nettype none
module shor_period_from_samples #(
	parameter int MOD_BITS = spfs_pkg::MOD_BITS_DEF
) (
	input wire logic   clk,
	input wire logic   arst_n,
	spfs_cfg_if.sink   cfg,
	spfs_in_if.sink    in_ch,
	spfs_out_if.source out_ch
);
	import spfs_pkg::*;
	localparam int BW = $clog2(MOD_BITS + 1);

	localparam logic [3:0] ST_IDLE = 4'd0, ST_CF_DIV = 4'd1, ST_CF_WAIT = 4'd2,
		ST_MP = 4'd3, ST_MQ = 4'd4, ST_CHK = 4'd5, ST_GCD_DIV = 4'd6,
		ST_GCD_WAIT = 4'd7, ST_LCM_DIV = 4'd8, ST_LCM_WAIT = 4'd9,
		ST_LCM_MUL = 4'd10, ST_FIN = 4'd11, ST_OUT = 4'd12;

	logic [3:0]  state_q;
	logic [15:0] modulus_q;
	logic [31:0] lcm_q;
	logic        ovf_q;
	logic        last_q;
	logic [64:0] u_q, v_q, a_q;
	logic [64:0] pp_q, qp_q, pc_q, qc_q;
	logic [64:0] acc_q;
	logic [1:0]  part_q;
	logic [7:0]  terms_q;
	logic [64:0] den_q;
	logic [64:0] ga_q, gb_q;
	div_req_t    dreq;
	div_rsp_t    drsp;

	spfs_div u_div (.clk(clk), .arst_n(arst_n), .req(dreq), .rsp(drsp));

	// b: bit length of modulus-1, clamped
	logic [15:0] nm1;
	logic [BW-1:0] b_len;
	always_comb begin
		nm1 = (modulus_q < 16'd2) ? 16'd1 : modulus_q - 16'd1;
		b_len = '0;
		for (int i = 0; i < 16; i++)
			if (nm1[i]) b_len = BW'(i + 1);
		if (b_len > BW'(MOD_BITS)) b_len = BW'(MOD_BITS);
	end
	logic [64:0] qt_w;
	assign qt_w = 65'd1 << {b_len, 1'b0};

	// shared 32x32 multiplier; low 64 bits of a 64x64 product done as partial products
	logic [31:0] ma, mb;
	logic [63:0] mprod;
	logic [64:0] mul_x, mul_y;
	always_comb begin
		unique case (state_q)
			ST_MP:   begin mul_x = a_q; mul_y = pc_q; end
			ST_MQ:   begin mul_x = a_q; mul_y = qc_q; end
			default: begin mul_x = ga_q; mul_y = den_q; end
		endcase
		unique case (part_q)
			2'd0:    begin ma = mul_x[31:0];  mb = mul_y[31:0];  end
			2'd1:    begin ma = mul_x[63:32]; mb = mul_y[31:0];  end
			2'd2:    begin ma = mul_x[31:0];  mb = mul_y[63:32]; end
			default: begin ma = mul_x[63:32]; mb = mul_y[63:32]; end
		endcase
	end
	assign mprod = ma * mb;
	logic [64:0] mterm;
	always_comb begin
		unique case (part_q)
			2'd0:    mterm = {1'b0, mprod};
			2'd1,
			2'd2:    mterm = {1'b0, mprod[31:0], 32'd0};
			default: mterm = '0;
		endcase
	end

	// closeness test: |pc*Q - s*qc| equals the remainder just produced, so v <= qc/2

	always_comb begin
		dreq.start = 1'b0;
		dreq.num = u_q;
		dreq.den = v_q;
		unique case (state_q)
			ST_CF_DIV:  dreq.start = 1'b1;
			ST_GCD_DIV: begin dreq.start = 1'b1; dreq.num = ga_q; dreq.den = gb_q; end
			ST_LCM_DIV: begin dreq.start = 1'b1; dreq.num = {33'd0, lcm_q}; dreq.den = ga_q; end
			default: ;
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign out_ch.valid = (state_q == ST_OUT);
	assign out_ch.period = lcm_q;
	assign out_ch.overflow = ovf_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			modulus_q <= MODULUS_RST;
			lcm_q     <= 32'd1;
			ovf_q     <= 1'b0;
			part_q    <= '0;
			last_q    <= 1'b0;
			u_q <= '0; v_q <= '0; a_q <= '0;
			pp_q <= '0; qp_q <= '0; pc_q <= '0; qc_q <= '0;
			acc_q <= '0;
			terms_q <= '0;
			den_q <= '0;
			ga_q <= '0; gb_q <= '0;
		end else begin
			if (cfg.valid) modulus_q <= cfg.data;
			unique case (state_q)
				ST_IDLE: if (in_ch.valid) begin
					last_q <= in_ch.last;
					u_q <= qt_w;
					v_q <= {33'd0, in_ch.sample} & (qt_w - 65'd1);
					pp_q <= 65'd1; qp_q <= '0; pc_q <= '0; qc_q <= 65'd1;
					terms_q <= '0;
					den_q <= 65'd1;
					state_q <= (({33'd0, in_ch.sample} & (qt_w - 65'd1)) == '0)
						? ST_FIN : ST_CF_DIV;
				end
				ST_CF_DIV: state_q <= ST_CF_WAIT;
				ST_CF_WAIT: if (drsp.done) begin
					a_q <= drsp.quo;
					u_q <= v_q;
					v_q <= drsp.rem;
					acc_q <= '0;
					part_q <= '0;
					state_q <= ST_MP;
				end
				ST_MP, ST_MQ: begin
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						acc_q <= '0;
						if (state_q == ST_MP) begin
							pp_q <= pc_q;
							pc_q <= acc_q + mterm + pp_q;
							state_q <= ST_MQ;
						end else begin
							qp_q <= qc_q;
							qc_q <= acc_q + mterm + qp_q;
							terms_q <= terms_q + 8'd1;
							state_q <= ST_CHK;
						end
					end else
						acc_q <= acc_q + mterm;
				end
				ST_CHK: begin
					den_q <= qc_q;
					if (v_q <= {1'b0, qc_q[64:1]} || v_q == '0 || terms_q == 8'd128)
						state_q <= ST_FIN;
					else
						state_q <= ST_CF_DIV;
				end
				ST_FIN: begin
					if (ovf_q) begin
						lcm_q <= LCM_MAX;
						state_q <= last_q ? ST_OUT : ST_IDLE;
					end else begin
						ga_q <= {33'd0, lcm_q};
						gb_q <= den_q;
						state_q <= (den_q == '0) ? ST_LCM_DIV : ST_GCD_DIV;
					end
				end
				ST_GCD_DIV: state_q <= ST_GCD_WAIT;
				ST_GCD_WAIT: if (drsp.done) begin
					ga_q <= gb_q;
					gb_q <= drsp.rem;
					state_q <= (drsp.rem == '0) ? ST_LCM_DIV : ST_GCD_DIV;
				end
				ST_LCM_DIV: begin
					if (ga_q == '0) ga_q <= 65'd1;
					else state_q <= ST_LCM_WAIT;
				end
				ST_LCM_WAIT: if (drsp.done) begin
					ga_q <= drsp.quo;
					acc_q <= '0;
					part_q <= '0;
					state_q <= ST_LCM_MUL;
				end
				ST_LCM_MUL: begin
					acc_q <= acc_q + mterm;
					part_q <= part_q + 2'd1;
					if (part_q == 2'd3) begin
						// a*q with a <= 2^32 and q <= 2^32 fits in 65 bits
						if (((acc_q + mterm) >> 32) != '0 || den_q[64:32] != '0) begin
							lcm_q <= LCM_MAX;
							ovf_q <= 1'b1;
						end else
							lcm_q <= acc_q[31:0] + mterm[31:0];
						state_q <= last_q ? ST_OUT : ST_IDLE;
					end
				end
				ST_OUT: if (out_ch.ready) begin
					lcm_q <= 32'd1;
					ovf_q <= 1'b0;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	a_out_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready)
		else $error("result shown while accepting samples");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.period))
		else $error("result dropped");
	a_ovf_sat: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> lcm_q == LCM_MAX || state_q == ST_LCM_MUL)
		else $error("overflow without saturation");
	a_lcm_nz: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> lcm_q != '0)
		else $error("lcm became zero");
endmodule
`default_nettype wire

// File: hw/rtl/spfs_div.sv
// shared restoring divider, one quotient bit per cycle
`default_nettype none
module spfs_div (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  spfs_pkg::div_req_t    req,
	output spfs_pkg::div_rsp_t    rsp
);
	import spfs_pkg::*;
	logic [64:0] quo_q;
	logic [64:0] rem_q;
	logic [64:0] den_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [65:0] trial;

	assign trial = {rem_q, quo_q[64]} - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd65;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			quo_q <= req.num;
			rem_q <= '0;
			den_q <= req.den;
		end else if (busy_q) begin
			if (!trial[65]) begin
				rem_q <= trial[64:0];
				quo_q <= {quo_q[63:0], 1'b1};
			end else begin
				rem_q <= {rem_q[63:0], quo_q[64]};
				quo_q <= {quo_q[63:0], 1'b0};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
	assign rsp.rem  = rem_q;
endmodule
`default_nettype wire

// File: tb/spfs_checker.sv
// passive checker: predicts the period results and compares them with the block output
`timescale 1ns / 100ps
module spfs_checker (
	input  logic clk,
	input  logic arst_n,
	spfs_cfg_if  cfg,
	spfs_in_if   in_ch,
	spfs_out_if  out_ch,
	output int   errors,
	output int   pending
);
	import spfs_pkg::*;

	typedef struct packed {
		logic [31:0] period;
		logic        overflow;
	} period_res_t;

	logic [15:0]       modulus_r;
	longint unsigned   lcm_acc;
	logic              ovf_acc;
	period_res_t       period_q[$];

	function automatic longint unsigned q_span(input logic [15:0] m);
		longint unsigned n;
		int b;
		n = (m < 2) ? 2 : m;
		n = n - 1;
		b = 0;
		while (n != 0) begin
			b++;
			n >>= 1;
		end
		if (b < 1) b = 1;
		if (b > MOD_BITS_DEF) b = MOD_BITS_DEF;
		return 64'd1 << (2 * b);
	endfunction

	// first convergent within 1/(2Q) of s/Q
	function automatic longint unsigned cf_den(input longint unsigned s,
			input longint unsigned qt);
		longint unsigned u, v, pp, qp, pc, qc, a, r, pn, qn, x, y, d;
		u = qt; v = s; pp = 1; qp = 0; pc = 0; qc = 1;
		for (int i = 0; i < 128 && v != 0; i++) begin
			a = u / v;
			r = u - a * v;
			pn = a * pc + pp;
			qn = a * qc + qp;
			pp = pc; qp = qc; pc = pn; qc = qn;
			u = v; v = r;
			x = pc * qt;
			y = s * qc;
			d = (x > y) ? x - y : y - x;
			if (d <= qc / 2) return qc;
		end
		return qc;
	endfunction

	function automatic longint unsigned gcd_u(input longint unsigned x,
			input longint unsigned y);
		longint unsigned t;
		while (y != 0) begin
			t = x % y;
			x = y;
			y = t;
		end
		return x;
	endfunction

	assign pending = period_q.size();

	always @(posedge clk or negedge arst_n) begin
		longint unsigned qt, s, den, g, a;
		period_res_t exp_r;
		if (!arst_n) begin
			modulus_r = MODULUS_RST;
			lcm_acc = 1;
			ovf_acc = 1'b0;
			errors = 0;
			period_q.delete();
		end else begin
			if (cfg.valid && cfg.ready)
				modulus_r = cfg.data;
			if (in_ch.valid && in_ch.ready) begin
				qt = q_span(modulus_r);
				s = longint'(in_ch.sample) & (qt - 1);
				den = (s == 0) ? 1 : cf_den(s, qt);
				if (ovf_acc) begin
					lcm_acc = LCM_MAX;
				end else begin
					g = gcd_u(lcm_acc, den);
					if (g == 0) g = 1;
					a = lcm_acc / g;
					if (a > longint'(LCM_MAX) / den) begin
						lcm_acc = LCM_MAX;
						ovf_acc = 1'b1;
					end else begin
						lcm_acc = a * den;
					end
				end
				if (in_ch.last) begin
					period_q.push_back('{lcm_acc[31:0], ovf_acc});
					lcm_acc = 1;
					ovf_acc = 1'b0;
				end
			end
			if (out_ch.valid && out_ch.ready) begin
				if (period_q.size() == 0) begin
					$error("unexpected result period=%0d overflow=%0d",
						out_ch.period, out_ch.overflow);
					errors++;
				end else begin
					exp_r = period_q.pop_front();
					if (out_ch.period !== exp_r.period) begin
						$error("period: expected %0d, got %0d", exp_r.period, out_ch.period);
						errors++;
					end
					if (out_ch.overflow !== exp_r.overflow) begin
						$error("overflow: expected %0d, got %0d",
							exp_r.overflow, out_ch.overflow);
						errors++;
					end
				end
			end
		end
	end
endmodule

// File: tb/tb_shor_period_from_samples.sv
// top of the period recovery testbench: clock, reset, request stimulus and verdict
`timescale 1ns / 100ps
module tb_shor_period_from_samples;
	import spfs_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic calm = 1'b0;
	int   errors, pending, n_sent;
	logic [15:0] cur_mod;

	spfs_cfg_if cfg ();
	spfs_in_if  in_ch ();
	spfs_out_if out_ch ();

	shor_period_from_samples dut (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch)
	);

	spfs_checker chk (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .in_ch(in_ch), .out_ch(out_ch),
		.errors(errors), .pending(pending)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	initial begin
		#200_000_000;
		$display("** shor_period_from_samples: FAILED **");
		$finish;
	end

	always @(posedge clk)
		out_ch.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 25);

	function automatic longint unsigned span_of(input logic [15:0] m);
		longint unsigned n;
		int b;
		n = (m < 2) ? 1 : m - 1;
		b = 0;
		while (n != 0) begin
			b++;
			n >>= 1;
		end
		if (b < 1) b = 1;
		return 64'd1 << (2 * b);
	endfunction

	task automatic write_modulus(input logic [15:0] m);
		in_ch.valid <= 1'b0;
		// the block has to drain before the modulus changes
		do @(posedge clk); while (pending != 0 || !in_ch.ready);
		cfg.valid <= 1'b1;
		cfg.data <= m;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
		cur_mod = m;
	endtask

	task automatic send_sample(input logic [31:0] s, input logic lst);
		while (!calm && $urandom_range(0, 99) < 25) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.sample <= s;
		in_ch.last <= lst;
		do @(posedge clk); while (!in_ch.ready);
		n_sent++;
	endtask

	// near k/r of Q, so the expansion stops on a short convergent
	function automatic logic [31:0] shaped_sample(input logic [15:0] m);
		longint unsigned qt, r, k, s;
		qt = span_of(m);
		r = 64'($urandom_range(2, 64));
		k = 64'($urandom_range(0, 32'(r - 1)));
		s = (k * qt + r / 2) / r;
		if ($urandom_range(0, 3) == 0) s = s + $urandom_range(0, 3) - 1;
		if ($urandom_range(0, 9) == 0) s = s | (longint'($urandom) << 0);
		return s[31:0];
	endfunction

	function automatic logic [15:0] pick_modulus();
		int c;
		c = $urandom_range(0, 99);
		if (c < 70) return 16'($urandom_range(2, 255));
		if (c < 90) return 16'($urandom_range(256, 4095));
		if (c < 97) return 16'($urandom_range(4096, 65535));
		return 16'($urandom_range(0, 1));
	endfunction

	initial begin
		int nsets, len;
		cfg.valid = 1'b0;
		cfg.data = '0;
		in_ch.valid = 1'b0;
		in_ch.sample = '0;
		in_ch.last = 1'b0;
		out_ch.ready = 1'b0;
		n_sent = 0;
		cur_mod = MODULUS_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset modulus: zero sample, extremes, masked high bits
		send_sample(32'd0, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'd1, 1'b0);
		send_sample(32'd128, 1'b1);
		send_sample(32'd85, 1'b1);
		// widest Q: denominator of 2^32 saturates, overflow stays for the set
		write_modulus(16'hFFFF);
		send_sample(32'd1, 1'b0);
		send_sample(32'h8000_0000, 1'b0);
		send_sample(32'd0, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b1);
		send_sample(32'h5555_5555, 1'b1);
		send_sample(32'hAAAA_AAAA, 1'b1);
		send_sample(32'h3333_3333, 1'b0);
		send_sample(32'h0F0F_0F0F, 1'b1);
		// modulus below 2 behaves as 2
		write_modulus(16'd0);
		send_sample(32'hFFFF_FFFE, 1'b0);
		send_sample(32'd3, 1'b1);
		write_modulus(16'd1);
		send_sample(32'd1, 1'b1);
		write_modulus(16'd2);
		send_sample(32'd2, 1'b0);
		send_sample(32'd3, 1'b1);
		write_modulus(16'd32768);
		send_sample(32'd7, 1'b1);

		while (n_sent < 1170) begin
			write_modulus(pick_modulus());
			nsets = $urandom_range(3, 10);
			for (int i = 0; i < nsets; i++) begin
				len = $urandom_range(1, 6);
				for (int j = 0; j < len; j++) begin
					calm = (n_sent >= 400 && n_sent < 550);
					send_sample($urandom_range(0, 4) == 0 ? $urandom
						: shaped_sample(cur_mod), j == len - 1);
				end
			end
		end
		in_ch.valid <= 1'b0;

		do @(posedge clk); while (pending != 0 || !in_ch.ready);
		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("** shor_period_from_samples: PASSED **");
		else
			$display("** shor_period_from_samples: FAILED **");
		$finish;
	end
endmodule
